// ----- rtl/gmcp_pkg.sv -----
package gmcp_pkg;

    localparam int REG_W     = 11;
    localparam int COST_W    = 16;
    localparam int PATH_W    = 27;
    localparam int SUM_W     = 28;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_ROWS  = 1024;
    localparam int DEF_MAX_COLS  = 1024;
    localparam int DEF_COST_BITS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_grid;
    } cell_flags_t;

    localparam int FLAGS_W = $bits(cell_flags_t);

endpackage

// ----- rtl/gmcp_ifs.sv -----
interface gmcp_cell_if import gmcp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink (input valid, input cell_cost, output ready);
endinterface

interface gmcp_path_if import gmcp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PATH_W-1:0] path_cost;

    modport source (output valid, output path_cost, input ready);
    modport sink (input valid, input path_cost, output ready);
endinterface

// ----- rtl/gmcp_front.sv -----
module gmcp_front import gmcp_pkg::*; #(
    parameter int  MAX_ROWS  = DEF_MAX_ROWS,
    parameter int  MAX_COLS  = DEF_MAX_COLS,
    parameter int  COST_BITS = DEF_COST_BITS,
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    gmcp_cell_if.sink            cells,
    input  logic                 q_full,
    output logic                 push,
    output logic [COST_W-1:0]    push_cost,
    output logic [COL_W-1:0]     push_col,
    output cell_flags_t          push_flags
);

    localparam logic [COST_W-1:0] COST_MASK = (COST_BITS >= COST_W) ? {COST_W{1'b1}} :
        COST_W'((64'd1 << COST_BITS) - 64'd1);

    logic [REG_W-1:0] num_rows_reg;
    logic [REG_W-1:0] num_cols_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [REG_W-1:0] rows_eff;
    logic [REG_W-1:0] cols_eff;
    logic [COL_W-1:0] col_idx;
    logic             last_col;
    logic             last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= REG_W'(1);
            num_cols_reg <= REG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_ROWS: num_rows_reg <= cfg_data;
                REG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (num_rows_reg == '0)
            rows_eff = REG_W'(1);
        else if (32'(num_rows_reg) > MAX_ROWS)
            rows_eff = REG_W'(MAX_ROWS);
        else
            rows_eff = num_rows_reg;

        if (num_cols_reg == '0)
            cols_eff = REG_W'(1);
        else if (32'(num_cols_reg) > MAX_COLS)
            cols_eff = REG_W'(MAX_COLS);
        else
            cols_eff = num_cols_reg;

        if (32'(col_reg) > MAX_COLS - 1)
            col_idx = COL_W'(MAX_COLS - 1);
        else
            col_idx = col_reg;
    end

    assign last_col = (32'(col_idx) + 32'd1) >= 32'(cols_eff);
    assign last_row = (32'(row_reg) + 32'd1) >= 32'(rows_eff);

    assign cells.ready = !q_full;
    assign push        = cells.valid && !q_full;
    assign push_cost   = cells.cell_cost & COST_MASK;
    assign push_col    = col_idx;

    always_comb
    begin
        push_flags.first_row = (row_reg == '0);
        push_flags.first_col = (col_idx == '0);
        push_flags.last_grid = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_idx + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- rtl/gmcp_queue.sv -----
module gmcp_queue #(
    parameter int W = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/gmcp_back.sv -----
module gmcp_back import gmcp_pkg::*; #(
    parameter int  MAX_COLS = DEF_MAX_COLS,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic [COST_W-1:0] q_cost,
    input  logic [COL_W-1:0]  q_col,
    input  cell_flags_t       q_flags,
    output logic              q_pop,
    gmcp_path_if.source       result
);

    logic [SUM_W-1:0]  line_mem [MAX_COLS];

    logic              s1_valid_reg;
    logic [COST_W-1:0] s1_cost_reg;
    logic [COL_W-1:0]  s1_col_reg;
    cell_flags_t       s1_flags_reg;
    logic [SUM_W-1:0]  up_mem_reg;
    logic              fwd_hit_reg;
    logic [SUM_W-1:0]  fwd_data_reg;
    logic [SUM_W-1:0]  left_reg;
    logic [SUM_W-1:0]  diag_reg;
    logic              out_valid_reg;
    logic [PATH_W-1:0] out_data_reg;

    logic              out_free;
    logic              exec;
    logic [SUM_W-1:0]  up;
    logic [SUM_W-1:0]  min_ud;
    logic [SUM_W-1:0]  best;
    logic [SUM_W-1:0]  sum;

    assign out_free = !out_valid_reg || result.ready;
    assign exec     = s1_valid_reg && (!s1_flags_reg.last_grid || out_free);
    assign q_pop    = q_valid && (!s1_valid_reg || exec);

    assign up     = fwd_hit_reg ? fwd_data_reg : up_mem_reg;
    assign min_ud = (up < diag_reg) ? up : diag_reg;

    always_comb
    begin
        if (s1_flags_reg.first_row && s1_flags_reg.first_col)
            best = '0;
        else if (s1_flags_reg.first_row)
            best = left_reg;
        else if (s1_flags_reg.first_col)
            best = up;
        else
            best = (left_reg < min_ud) ? left_reg : min_ud;
    end

    assign sum = best + SUM_W'(s1_cost_reg);

    always_ff @(posedge clk)
    begin
        if (exec)
            line_mem[s1_col_reg] <= sum;
        if (q_pop)
            up_mem_reg <= line_mem[q_col];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_cost_reg  <= q_cost;
            s1_col_reg   <= q_col;
            fwd_hit_reg  <= exec && (s1_col_reg == q_col);
            fwd_data_reg <= sum;
        end
        if (exec)
        begin
            left_reg <= sum;
            diag_reg <= up;
        end
        if (exec && s1_flags_reg.last_grid)
            out_data_reg <= sum[PATH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flags_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
                s1_flags_reg <= q_flags;
            end
            else if (exec)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (exec && s1_flags_reg.last_grid)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.path_cost = out_data_reg;

endmodule

// ----- rtl/grid_min_cost_path.sv -----
// Minimum-cost path through a cost grid with down, right and diagonal moves.
// The cells arrive on the cells channel in row-major order, one item per cell.
// The grid size is written on the configuration port: index 0 sets the row
// count and index 1 the column count, and both reset to one.
// After the last cell of a grid, one item on the result channel carries the
// least path cost from the top-left cell to the bottom-right cell.
// The block takes one cell per cycle while its queue is not full, with a three-way
// minimum and one add per cell against a line buffer of the previous row's sums that
// is read and written at most once per cycle.
// A result passes from the queue into the stage-1 registers and then into the output
// register, where it is shown as valid.
// When the receiver stalls, the result holds in the output register while the
// next cells keep flowing; the block stops taking cells only when a second
// result is ready behind the held one and the two-entry queue has filled.
// Reset returns the sizes to one and the position to the top-left cell.
// The line buffer is not cleared; each row reads only what the row above wrote.
module grid_min_cost_path import gmcp_pkg::*; #(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    gmcp_cell_if.sink            cells,
    gmcp_path_if.source          result
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int Q_W   = COST_W + COL_W + FLAGS_W;

    logic              push;
    logic [COST_W-1:0] push_cost;
    logic [COL_W-1:0]  push_col;
    cell_flags_t       push_flags;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    logic [Q_W-1:0]    q_head;
    logic [COST_W-1:0] q_cost;
    logic [COL_W-1:0]  q_col;
    cell_flags_t       q_flags;

    gmcp_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .COST_BITS (COST_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cells      (cells),
        .q_full     (q_full),
        .push       (push),
        .push_cost  (push_cost),
        .push_col   (push_col),
        .push_flags (push_flags)
    );

    gmcp_queue #(
        .W (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_cost, push_col, push_flags}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign {q_cost, q_col, q_flags} = q_head;

    gmcp_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cost  (q_cost),
        .q_col   (q_col),
        .q_flags (q_flags),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// ----- rtl/gmcp_checker.sv -----
module gmcp_checker import gmcp_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              cells_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [PATH_W-1:0] result_cost
);

    assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("Result valid during reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("Result dropped while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_cost))
        else $error("Result cost changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(result_ready) && $past(result_ready, 2) |-> cells_ready)
        else $error("Cells refused although the result side kept flowing.");

endmodule

bind grid_min_cost_path gmcp_checker u_gmcp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cells_ready  (cells.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_cost  (result.path_cost)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import gmcp_pkg::*;

    localparam int RESULT_LATENCY = 3;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 5;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_CELLS   = 1000;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int PLAN_LEN       = 33;

    typedef enum logic [1:0] {
        STEP_CELL,
        STEP_ROWS,
        STEP_COLS
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t        kind;
        logic [15:0]       value;
        logic              typed;
        logic [PATH_W-1:0] want;
    } plan_step_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    gmcp_cell_if cell_ch ();
    gmcp_path_if path_ch ();

    grid_min_cost_path dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cell_ch),
        .result    (path_ch)
    );

    // Running state of the path-sum recurrence, mirrored from the block.
    logic [SUM_W-1:0] line_sums [DEF_MAX_COLS];
    logic [SUM_W-1:0] run_left;
    logic [SUM_W-1:0] run_diag;
    logic [9:0]       at_col;
    logic [9:0]       at_row;
    logic [REG_W-1:0] rows_reg;
    logic [REG_W-1:0] cols_reg;

    logic [PATH_W-1:0] expected_paths [$];

    int  cycle_count;
    int  failures;
    int  cells_sent;
    int  grids_done;
    int  results_seen;
    int  reg_writes;
    int  peak_rows;
    int  peak_cols;
    int  hold_request;
    bit  tx_choppy;
    bit  rx_choppy;

    plan_step_t directed_plan [PLAN_LEN] = '{
        '{STEP_CELL, 16'd0,     1'b1, 27'd0},
        '{STEP_CELL, 16'd65535, 1'b1, 27'd65535},
        '{STEP_ROWS, 16'd0,     1'b0, 27'd0},
        '{STEP_COLS, 16'd0,     1'b0, 27'd0},
        '{STEP_CELL, 16'd1234,  1'b1, 27'd1234},
        '{STEP_ROWS, 16'd2,     1'b0, 27'd0},
        '{STEP_COLS, 16'd2,     1'b0, 27'd0},
        '{STEP_CELL, 16'd1,     1'b0, 27'd0},
        '{STEP_CELL, 16'd2,     1'b0, 27'd0},
        '{STEP_CELL, 16'd3,     1'b0, 27'd0},
        '{STEP_CELL, 16'd4,     1'b0, 27'd0},
        '{STEP_CELL, 16'd65535, 1'b0, 27'd0},
        '{STEP_CELL, 16'd65535, 1'b0, 27'd0},
        '{STEP_CELL, 16'd65535, 1'b0, 27'd0},
        '{STEP_CELL, 16'd65535, 1'b1, 27'd131070},
        '{STEP_ROWS, 16'd1,     1'b0, 27'd0},
        '{STEP_COLS, 16'd3,     1'b0, 27'd0},
        '{STEP_CELL, 16'd7,     1'b0, 27'd0},
        '{STEP_CELL, 16'd0,     1'b0, 27'd0},
        '{STEP_CELL, 16'd65535, 1'b1, 27'd65542},
        '{STEP_ROWS, 16'd3,     1'b0, 27'd0},
        '{STEP_COLS, 16'd4,     1'b0, 27'd0},
        '{STEP_CELL, 16'd10,    1'b0, 27'd0},
        '{STEP_CELL, 16'd20,    1'b0, 27'd0},
        '{STEP_CELL, 16'd30,    1'b0, 27'd0},
        '{STEP_CELL, 16'd40,    1'b0, 27'd0},
        '{STEP_CELL, 16'd5,     1'b0, 27'd0},
        '{STEP_CELL, 16'd6,     1'b0, 27'd0},
        '{STEP_COLS, 16'd2,     1'b0, 27'd0},
        '{STEP_CELL, 16'd7,     1'b0, 27'd0},
        '{STEP_ROWS, 16'd2,     1'b0, 27'd0},
        '{STEP_CELL, 16'd8,     1'b0, 27'd0},
        '{STEP_CELL, 16'd9,     1'b0, 27'd0}
    };

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, expected_paths.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int eff_size(input logic [REG_W-1:0] raw, input int cap);
        if (raw == 0)
            return 1;
        if (raw > cap)
            return cap;
        return int'(raw);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 30)
            return COST_W'($urandom_range(0, 15));
        return COST_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [REG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 70)
            return REG_W'($urandom_range(1, 4));
        if (r < 93)
            return REG_W'($urandom_range(5, 10));
        return REG_W'($urandom_range(11, 24));
    endfunction

    // Adds one cell to the running sums; returns 1 when it closes a grid.
    function automatic bit path_step(input logic [COST_W-1:0] cost,
                                     output logic [PATH_W-1:0] total);
        int               rows;
        int               cols;
        int               j;
        logic [SUM_W-1:0] up;
        logic [SUM_W-1:0] best;
        logic [SUM_W-1:0] sum;
        rows = eff_size(rows_reg, DEF_MAX_ROWS);
        cols = eff_size(cols_reg, DEF_MAX_COLS);
        j    = int'(at_col);
        up   = line_sums[j];
        if (at_row == 0 && j == 0)
            best = '0;
        else if (at_row == 0)
            best = run_left;
        else if (j == 0)
            best = up;
        else
        begin
            best = run_left;
            if (up < best)
                best = up;
            if (run_diag < best)
                best = run_diag;
        end
        sum          = best + cost;
        run_diag     = up;
        line_sums[j] = sum;
        run_left     = sum;
        total        = sum[PATH_W-1:0];
        if (j + 1 >= cols)
        begin
            at_col   = '0;
            run_left = '0;
            run_diag = '0;
            if (int'(at_row) + 1 >= rows)
            begin
                at_row = '0;
                return 1'b1;
            end
            at_row = at_row + 1'b1;
        end
        else
            at_col = 10'(j + 1);
        return 1'b0;
    endfunction

    task automatic flag_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic send_cell(input logic [COST_W-1:0] cost, input logic typed,
                             input logic [PATH_W-1:0] want);
        int                gap;
        logic [PATH_W-1:0] total;
        gap = tx_choppy ? pick_gap() : 0;
        if (gap > 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_ch.valid     <= 1'b1;
        cell_ch.cell_cost <= cost;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
        cells_sent++;
        if (path_step(cost, total))
        begin
            expected_paths.push_back(typed ? want : total);
            grids_done++;
        end
    endtask

    task automatic run_grid();
        do
            send_cell(pick_cost(), 1'b0, '0);
        while (at_col != 0 || at_row != 0);
    endtask

    task automatic drain_paths();
        cell_ch.valid <= 1'b0;
        while (expected_paths.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_NUM_ROWS)
            rows_reg = val;
        else
            cols_reg = val;
        reg_writes++;
        if (eff_size(rows_reg, DEF_MAX_ROWS) > peak_rows)
            peak_rows = eff_size(rows_reg, DEF_MAX_ROWS);
        if (eff_size(cols_reg, DEF_MAX_COLS) > peak_cols)
            peak_cols = eff_size(cols_reg, DEF_MAX_COLS);
    endtask

    initial
    begin
        logic [PATH_W-1:0] want;
        int                stall_left;
        stall_left    = 0;
        path_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && path_ch.valid && path_ch.ready)
            begin
                results_seen++;
                if (expected_paths.size() == 0)
                    flag_failure($sformatf("path_cost %0d arrived with no grid pending",
                                           path_ch.path_cost));
                else
                begin
                    want = expected_paths.pop_front();
                    if (path_ch.path_cost !== want)
                        flag_failure($sformatf("path_cost expected %0d, got %0d",
                                               want, path_ch.path_cost));
                end
            end
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && rx_choppy && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                path_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                path_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int               base_cells;
        int               waited;
        logic [REG_W-1:0] new_cols;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_NUM_ROWS;
        cfg_data          = '0;
        cell_ch.valid     = 1'b0;
        cell_ch.cell_cost = '0;
        cycle_count       = 0;
        failures          = 0;
        cells_sent        = 0;
        grids_done        = 0;
        results_seen      = 0;
        reg_writes        = 0;
        peak_rows         = 1;
        peak_cols         = 1;
        hold_request      = 0;
        tx_choppy         = 1'b1;
        rx_choppy         = 1'b1;
        rows_reg          = REG_W'(1);
        cols_reg          = REG_W'(1);
        run_left          = '0;
        run_diag          = '0;
        at_col            = '0;
        at_row            = '0;
        for (int k = 0; k < DEF_MAX_COLS; k++)
            line_sums[k] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int s = 0; s < PLAN_LEN; s++)
        begin
            if (directed_plan[s].kind == STEP_CELL)
                send_cell(directed_plan[s].value[COST_W-1:0], directed_plan[s].typed,
                          directed_plan[s].want);
            else
            begin
                drain_paths();
                write_reg(directed_plan[s].kind == STEP_ROWS ? REG_NUM_ROWS : REG_NUM_COLS,
                          directed_plan[s].value[REG_W-1:0]);
            end
        end

        // Widest and tallest grids, then a shrink of both sizes in the middle of one.
        drain_paths();
        tx_choppy = 1'b0;
        write_reg(REG_NUM_ROWS, 11'd1);
        write_reg(REG_NUM_COLS, 11'd2047);
        run_grid();
        drain_paths();
        write_reg(REG_NUM_ROWS, 11'd1024);
        write_reg(REG_NUM_COLS, 11'd1);
        run_grid();
        drain_paths();
        write_reg(REG_NUM_ROWS, 11'd2047);
        write_reg(REG_NUM_COLS, 11'd12);
        repeat (30) send_cell(pick_cost(), 1'b0, '0);
        drain_paths();
        write_reg(REG_NUM_COLS, 11'd3);
        write_reg(REG_NUM_ROWS, 11'd3);
        run_grid();

        // One-cell grids against a stalled receiver fill the block up.
        drain_paths();
        write_reg(REG_NUM_ROWS, 11'd1);
        write_reg(REG_NUM_COLS, 11'd1);
        hold_request = HOLD_CYCLES;
        repeat (40) send_cell(pick_cost(), 1'b0, '0);
        drain_paths();

        base_cells = cells_sent;
        while (cells_sent - base_cells < RANDOM_CELLS)
        begin
            drain_paths();
            tx_choppy = $urandom_range(0, 3) != 0;
            rx_choppy = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_NUM_ROWS, pick_size());
            if ($urandom_range(0, 2) != 0)
            begin
                new_cols = pick_size();
                if ((at_col != 0 || at_row != 0) &&
                    eff_size(new_cols, DEF_MAX_COLS) > eff_size(cols_reg, DEF_MAX_COLS))
                    new_cols = REG_W'($urandom_range(0, eff_size(cols_reg, DEF_MAX_COLS)));
                write_reg(REG_NUM_COLS, new_cols);
            end
            repeat ($urandom_range(1, 3)) run_grid();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) send_cell(pick_cost(), 1'b0, '0);
        end

        cell_ch.valid <= 1'b0;
        waited = 0;
        while (expected_paths.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_paths.size() != 0)
            flag_failure($sformatf("%0d grid results never arrived", expected_paths.size()));

        $display("Ran %0d cells through %0d grids with %0d size writes, up to %0d x %0d.",
                 cells_sent, grids_done, reg_writes, peak_rows, peak_cols);
        $display("Checked %0d path costs, %0d failures.", results_seen, failures);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/gmcp_pkg.sv
rtl/gmcp_ifs.sv
rtl/gmcp_front.sv
rtl/gmcp_queue.sv
rtl/gmcp_back.sv
rtl/grid_min_cost_path.sv
rtl/gmcp_checker.sv
test/testbench.sv
